FILE: design/lfpd_pkg.sv
package lfpd_pkg;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int ONE_Q10    = 1024;
    localparam int ACTIVE_MIN = 184;
    localparam int ALPHA_OLD  = 563;
    localparam int ALPHA_NEW  = 461;
    localparam int DRIVE_MIN  = 85;
    localparam int DRIVE_MAX  = 230;
    localparam int SPAN_MIN   = 25;
    localparam int NUM_LANES  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3 * SAMPLE_BITS_DEF;

    localparam logic [CFG_IDX_W-1:0] REG_WHITE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_L = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_R = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONF   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LANES, ST_DIV, ST_FILT, ST_PD, ST_OUT
    } t_state;

    // restoring divider control
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;
endpackage

FILE: design/lfpd_if.sv
interface lfpd_in_if
    import lfpd_pkg::*;
#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_left;
    logic [SAMPLE_BITS-1:0] sample_centre;
    logic [SAMPLE_BITS-1:0] sample_right;
    modport source (output valid, sample_left, sample_centre, sample_right, input ready);
    modport sink   (input valid, sample_left, sample_centre, sample_right, output ready);
endinterface

interface lfpd_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        left_speed;
    logic [7:0]        right_speed;
    logic              left_backward;
    logic              right_backward;
    logic              tracking;
    logic signed [11:0] smoothed_error;
    modport source (output valid, left_speed, right_speed, left_backward, right_backward,
                    tracking, smoothed_error, input ready);
    modport sink   (input valid, left_speed, right_speed, left_backward, right_backward,
                    tracking, smoothed_error, output ready);
endinterface

FILE: design/lfpd_div.sv
// Unsigned restoring divider, one quotient bit per cycle, round to nearest.
module lfpd_div
    import lfpd_pkg::*;
#(
    parameter int NW = 22,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_num, r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   w_sh;
    logic [DW+1:0] w_twice;

    assign w_sh    = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_twice = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    // round: remainder*2 >= den bumps the quotient
                    if (w_twice >= {2'b00, r_den}) r_quo <= r_quo + 1'b1;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_num <= r_num << 1;
                    if (w_sh >= {1'b0, r_den}) begin
                        r_rem <= w_sh - {1'b0, r_den};
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_sh;
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: design/lfpd_lane.sv
// One sensor: calibrated strength in Q1.10 with dead band.
module lfpd_lane
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_raw,
    input  logic [SAMPLE_BITS-1:0] i_white,
    input  logic [SAMPLE_BITS-1:0] i_black,
    output logic                   o_done,
    output logic [10:0]            o_strength
);
    localparam int NW = SAMPLE_BITS + 11;
    logic signed [SAMPLE_BITS+1:0] w_span;
    logic                          w_narrow;
    logic [NW-1:0]                 w_num;
    logic [SAMPLE_BITS-1:0]        w_den;
    logic [NW-1:0]                 w_quo;
    logic                          w_done;
    logic                          r_sat0, r_sat1;
    logic [10:0]                   w_s;

    assign w_span   = $signed({2'b00, i_black}) - $signed({2'b00, i_white});
    assign w_narrow = w_span < $signed((SAMPLE_BITS+2)'(SPAN_MIN));
    assign w_num    = w_narrow ? (NW'(i_raw) << 10) : (NW'(i_raw - i_white) << 10);
    assign w_den    = w_narrow ? {SAMPLE_BITS{1'b1}} : w_span[SAMPLE_BITS-1:0];

    lfpd_div #(.NW(NW), .DW(SAMPLE_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quo(w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat0 <= !w_narrow && (i_raw <= i_white);
            r_sat1 <= !w_narrow && (i_raw >= i_black);
        end
    end

    always_comb begin
        if (r_sat0) w_s = '0;
        else if (r_sat1) w_s = 11'(ONE_Q10);
        else if (w_quo > NW'(ONE_Q10)) w_s = 11'(ONE_Q10);
        else w_s = w_quo[10:0];
    end
    assign o_done     = w_done;
    assign o_strength = (w_s > 11'(ACTIVE_MIN)) ? w_s : '0;
endmodule

FILE: design/line_follow_pd_steering.sv
// Three-sensor line follower with PD steering.
// Input channel: one word of three raw samples (left, centre, right).
// Output channel: one word per input: two motor duties, direction bits,
// tracking flag and the filtered error in Q1.10.
// Configuration: write enable, index 0..7 and data; write only while idle.
// Three lanes convert the samples to strengths in parallel, each with its
// own bit-serial divider; in the cycle in which they finish, the merge
// stage starts a fourth divider for the centroid error, then the filter,
// PD and output states follow in order. A searching result goes from the
// lanes straight to the output register; one item is in work at a time.
// The result waits in the output register while the receiver stalls; the
// next word is taken the cycle after the result has been taken.
// Reset loads the listed register defaults and zeroes the filter state,
// with the line taken as last seen on the right.
module line_follow_pd_steering
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lfpd_in_if.sink                    s_in,
    lfpd_out_if.source                 m_out,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [3*SAMPLE_BITS-1:0]   i_cfg_data
);
    localparam int LW = 3 * SAMPLE_BITS;
    localparam int EW = 23;

    logic [LW-1:0] r_white, r_black;
    logic [11:0]   r_kp, r_kd, r_conf;
    logic [7:0]    r_base_l, r_base_r, r_search;

    t_state r_state, n_state;
    logic signed [11:0] r_filt, r_prev;
    logic               r_seen_left;
    logic               r_neg;
    logic signed [11:0] r_err, r_f;
    logic signed [27:0] r_corr;
    logic [7:0]         r_lspd, r_rspd;
    logic               r_lbk, r_rbk, r_trk, r_oval;
    logic signed [11:0] r_oerr;

    logic [NUM_LANES-1:0] w_ldone;
    logic                 w_lanes_done;
    logic [10:0]          w_str [NUM_LANES];
    logic [SAMPLE_BITS-1:0] w_raw [NUM_LANES];
    t_div_ctl             w_dc;
    logic [EW-1:0]        w_enum, w_quo;

    assign w_raw[0] = s_in.sample_left;
    assign w_raw[1] = s_in.sample_centre;
    assign w_raw[2] = s_in.sample_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white  <= LW'(544695730);
            r_black  <= LW'(1039101907);
            r_kp     <= 12'd384;
            r_kd     <= 12'd880;
            r_base_l <= 8'd155;
            r_base_r <= 8'd165;
            r_search <= 8'd120;
            r_conf   <= 12'd666;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WHITE:  r_white  <= i_cfg_data;
                REG_BLACK:  r_black  <= i_cfg_data;
                REG_KP:     r_kp     <= i_cfg_data[11:0];
                REG_KD:     r_kd     <= i_cfg_data[11:0];
                REG_BASE_L: r_base_l <= i_cfg_data[7:0];
                REG_BASE_R: r_base_r <= i_cfg_data[7:0];
                REG_SEARCH: r_search <= i_cfg_data[7:0];
                REG_CONF:   r_conf   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic w_accept;
    assign w_accept = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == ST_IDLE) && !r_oval;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lfpd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_accept),
            .i_raw(w_raw[g]),
            .i_white(r_white[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_black(r_black[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_done(w_ldone[g]), .o_strength(w_str[g])
        );
    end

    // lanes run in lockstep
    assign w_lanes_done = &w_ldone;

    // merge: |sR - sL| * 1024 / sum
    logic signed [11:0] w_diff;
    logic [10:0]        w_adiff;
    logic [12:0]        w_sum;
    assign w_sum   = 13'(w_str[0]) + 13'(w_str[1]) + 13'(w_str[2]);
    assign w_diff  = $signed({1'b0, w_str[2]}) - $signed({1'b0, w_str[0]});
    assign w_adiff = w_diff[11] ? 11'(-w_diff) : w_diff[10:0];
    assign w_enum  = EW'(w_adiff) << 10;
    assign w_dc.start = (r_state == ST_LANES) && w_lanes_done && (w_sum != '0)
                        && !(w_sum < {1'b0, r_conf});

    lfpd_div #(.NW(EW), .DW(13)) u_mdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dc.start),
        .i_num(w_enum), .i_den(w_sum), .o_done(w_dc.done), .o_quo(w_quo)
    );

    // filter and PD arithmetic
    logic signed [23:0] w_facc, w_fabs_r;
    logic [23:0]        w_fmag;
    logic signed [13:0] w_fq;
    logic signed [11:0] w_fcl;
    logic signed [12:0] w_dd;
    logic signed [27:0] w_corr;
    logic signed [29:0] w_lacc, w_racc;
    logic signed [15:0] w_lq, w_rq;
    logic [7:0]         w_lc, w_rc;

    assign w_facc = 24'(ALPHA_OLD) * 24'(r_filt) + 24'(ALPHA_NEW) * 24'(r_err);
    assign w_fmag = w_facc[23] ? 24'(-w_facc) : w_facc;
    assign w_fabs_r = $signed((w_fmag + 24'd512) >> 10);
    assign w_fq   = w_facc[23] ? -w_fabs_r[13:0] : w_fabs_r[13:0];
    assign w_fcl  = (w_fq > 14'sd1024) ? 12'sd1024 :
                    (w_fq < -14'sd1024) ? -12'sd1024 : w_fq[11:0];
    assign w_dd   = 13'(r_f) - 13'(r_prev);
    assign w_corr = $signed({1'b0, r_kp}) * 28'(r_f) + $signed({1'b0, r_kd}) * 28'(w_dd);

    function automatic logic signed [15:0] rnd14(input logic signed [29:0] v);
        logic [29:0] m;
        logic [29:0] q;
        m = v[29] ? 30'(-v) : 30'(v);
        q = (m + 30'd8192) >> 14;
        return v[29] ? -16'(q) : 16'(q);
    endfunction

    assign w_lacc = $signed({1'b0, r_base_l, 14'd0}) + 30'(r_corr);
    assign w_racc = $signed({1'b0, r_base_r, 14'd0}) - 30'(r_corr);
    assign w_lq = rnd14(w_lacc);
    assign w_rq = rnd14(w_racc);
    assign w_lc = (w_lq < 16'sd85) ? 8'(DRIVE_MIN) : (w_lq > 16'sd230) ? 8'(DRIVE_MAX) : w_lq[7:0];
    assign w_rc = (w_rq < 16'sd85) ? 8'(DRIVE_MIN) : (w_rq > 16'sd230) ? 8'(DRIVE_MAX) : w_rq[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_LANES;
            ST_LANES: if (w_lanes_done) begin
                if (w_sum < {1'b0, r_conf}) n_state = ST_OUT;
                else if (w_sum == '0) n_state = ST_FILT;
                else n_state = ST_DIV;
            end
            ST_DIV:   if (w_dc.done) n_state = ST_FILT;
            ST_FILT:  n_state = ST_PD;
            ST_PD:    n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LANES && w_lanes_done) begin
            r_neg <= (w_str[2] < w_str[0]);
            r_err <= '0;
        end
        if (w_dc.done) r_err <= r_neg ? -12'(w_quo) : 12'(w_quo);
        if (r_state == ST_PD) r_corr <= w_corr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt      <= '0;
            r_prev      <= '0;
            r_seen_left <= 1'b0;
            r_oval      <= 1'b0;
            r_trk       <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready) r_oval <= 1'b0;
            if (r_state == ST_LANES && w_lanes_done) r_trk <= !(w_sum < {1'b0, r_conf});
            if (r_state == ST_FILT) begin
                r_f <= w_fcl;
            end
            if (r_state == ST_PD) begin
                r_filt      <= r_f;
                r_prev      <= r_f;
                r_seen_left <= r_f[11];
            end
            if (r_state == ST_OUT) begin
                r_oval <= 1'b1;
                if (r_trk) begin
                    r_lspd <= w_lc;
                    r_rspd <= w_rc;
                    r_lbk  <= 1'b0;
                    r_rbk  <= 1'b0;
                end else begin
                    r_lspd <= r_search;
                    r_rspd <= r_search;
                    r_lbk  <= r_seen_left;
                    r_rbk  <= !r_seen_left;
                end
                r_oerr <= r_filt;
            end
        end
    end

    assign m_out.valid          = r_oval;
    assign m_out.left_speed     = r_lspd;
    assign m_out.right_speed    = r_rspd;
    assign m_out.left_backward  = r_lbk;
    assign m_out.right_backward = r_rbk;
    assign m_out.tracking       = r_trk;
    assign m_out.smoothed_error = r_oerr;
endmodule

FILE: sim/lfpd_steer_checker.sv
`timescale 1ns / 100ps
module lfpd_steer_checker
    import lfpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfpd_in_if          s_in,
    lfpd_out_if         m_out,
    input  logic        i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_tracked,
    output int          o_searched
);
    typedef struct packed {
        logic [7:0]         left_speed;
        logic [7:0]         right_speed;
        logic               left_backward;
        logic               right_backward;
        logic               tracking;
        logic signed [11:0] smoothed_error;
    } t_drive;

    logic [29:0] white_lv, black_lv;
    logic [11:0] kp, kd, conf_min;
    logic [7:0]  base_l, base_r, search_spd;
    longint      filt, prev_filt;
    bit          seen_left;
    t_drive      drive_q[$];

    function automatic longint div_near(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic longint strength(logic [9:0] raw, int lane);
        longint w, b, span, s;
        w = (white_lv >> (lane * 10)) & 10'h3ff;
        b = (black_lv >> (lane * 10)) & 10'h3ff;
        span = b - w;
        if (span < SPAN_MIN) s = div_near(longint'(raw) * ONE_Q10, 1023);
        else if (raw <= w) s = 0;
        else if (raw >= b) s = ONE_Q10;
        else s = div_near((longint'(raw) - w) * ONE_Q10, span);
        s = clip(s, 0, ONE_Q10);
        return (s > ACTIVE_MIN) ? s : 0;
    endfunction

    function automatic t_drive steer(logic [9:0] l, logic [9:0] c, logic [9:0] r);
        t_drive t;
        longint sl, sc, sr, sum, e, f, d, corr;
        sl = strength(l, 0);
        sc = strength(c, 1);
        sr = strength(r, 2);
        sum = sl + sc + sr;
        if (sum >= conf_min) begin
            e = (sum > 0) ? div_near((sr - sl) * ONE_Q10, sum) : 0;
            f = clip(div_near(ALPHA_OLD * filt + ALPHA_NEW * e, ONE_Q10), -ONE_Q10, ONE_Q10);
            d = f - prev_filt;
            filt = f;
            prev_filt = f;
            seen_left = (f < 0);
            corr = longint'(kp) * f + longint'(kd) * d;
            t.left_speed  = 8'(clip(div_near(longint'(base_l) * 16384 + corr, 16384),
                                    DRIVE_MIN, DRIVE_MAX));
            t.right_speed = 8'(clip(div_near(longint'(base_r) * 16384 - corr, 16384),
                                    DRIVE_MIN, DRIVE_MAX));
            t.left_backward = 0;
            t.right_backward = 0;
            t.tracking = 1;
        end else begin
            t.left_speed = search_spd;
            t.right_speed = search_spd;
            t.left_backward = seen_left;
            t.right_backward = !seen_left;
            t.tracking = 0;
        end
        t.smoothed_error = filt[11:0];
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_drive got, want;
        if (!i_rst_n) begin
            white_lv <= 30'd544695730;
            black_lv <= 30'd1039101907;
            kp <= 12'd384;
            kd <= 12'd880;
            base_l <= 8'd155;
            base_r <= 8'd165;
            search_spd <= 8'd120;
            conf_min <= 12'd666;
            filt = 0;
            prev_filt = 0;
            seen_left = 0;
            drive_q.delete();
            o_errors <= 0;
            o_pending <= 0;
            o_tracked <= 0;
            o_searched <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WHITE:  white_lv <= i_cfg_data[29:0];
                    REG_BLACK:  black_lv <= i_cfg_data[29:0];
                    REG_KP:     kp <= i_cfg_data[11:0];
                    REG_KD:     kd <= i_cfg_data[11:0];
                    REG_BASE_L: base_l <= i_cfg_data[7:0];
                    REG_BASE_R: base_r <= i_cfg_data[7:0];
                    REG_SEARCH: search_spd <= i_cfg_data[7:0];
                    REG_CONF:   conf_min <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (s_in.valid && s_in.ready)
                drive_q.push_back(steer(s_in.sample_left, s_in.sample_centre,
                                        s_in.sample_right));
            if (m_out.valid && m_out.ready) begin
                got = {m_out.left_speed, m_out.right_speed, m_out.left_backward,
                       m_out.right_backward, m_out.tracking, m_out.smoothed_error};
                if (drive_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected word %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = drive_q.pop_front();
                    if (want.tracking) o_tracked <= o_tracked + 1;
                    else o_searched <= o_searched + 1;
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("mismatch: exp L%0d R%0d lb%b rb%b t%b e%0d, got L%0d R%0d lb%b rb%b t%b e%0d",
                                want.left_speed, want.right_speed, want.left_backward,
                                want.right_backward, want.tracking, want.smoothed_error,
                                got.left_speed, got.right_speed, got.left_backward,
                                got.right_backward, got.tracking, got.smoothed_error);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= drive_q.size();
        end
    end
endmodule

FILE: sim/line_follow_pd_steering_test.sv
`timescale 1ns / 100ps
module line_follow_pd_steering_test;
    import lfpd_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_WHITE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int errors, pending, tracked, searched;
    int words_sent;

    lfpd_in_if  s_in();
    lfpd_out_if m_out();

    line_follow_pd_steering u_top (
        .i_clk, .i_rst_n, .s_in(s_in.sink), .m_out(m_out.source),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    lfpd_steer_checker u_chk (
        .i_clk, .i_rst_n, .s_in, .m_out, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_tracked(tracked), .o_searched(searched)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    // receiver stalls at random; some phases run with no stalls
    bit steady_rx;
    always @(posedge i_clk) begin
        if (!i_rst_n) m_out.ready <= 0;
        else m_out.ready <= steady_rx ? 1'b1 : ($urandom_range(9) < 6);
    end

    // valid stays up after an accept only when the next word follows at once
    task automatic send_word(logic [9:0] l, logic [9:0] c, logic [9:0] r, bit steady);
        int g;
        g = steady ? 0 : gap_len();
        if (g != 0) begin
            s_in.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_in.valid <= 1;
        s_in.sample_left <= l;
        s_in.sample_centre <= c;
        s_in.sample_right <= r;
        do @(posedge i_clk); while (!s_in.ready);
        words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_in.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // line-like samples: random levels near calibration, mostly one hot sensor
    task automatic track_burst(int n, bit steady);
        logic [9:0] v[3];
        int hot;
        repeat (n) begin
            hot = $urandom_range(2);
            for (int k = 0; k < 3; k++)
                v[k] = (k == hot || $urandom_range(3) == 0) ? 10'($urandom_range(1023, 500))
                                                             : 10'($urandom_range(400));
            if ($urandom_range(9) == 0)
                for (int k = 0; k < 3; k++) v[k] = 10'($urandom);
            send_word(v[0], v[1], v[2], steady);
        end
    endtask

    task automatic random_config();
        logic [9:0] w[3], b[3];
        for (int k = 0; k < 3; k++) begin
            w[k] = 10'($urandom_range(500));
            b[k] = ($urandom_range(5) == 0) ? 10'(w[k] + $urandom_range(30) - 5)
                                            : 10'(w[k] + $urandom_range(523, 25));
        end
        write_reg(REG_WHITE, {w[2], w[1], w[0]});
        write_reg(REG_BLACK, {b[2], b[1], b[0]});
        write_reg(REG_KP, CFG_DATA_W'($urandom_range(4095)));
        write_reg(REG_KD, CFG_DATA_W'($urandom_range(4095)));
        write_reg(REG_BASE_L, CFG_DATA_W'($urandom_range(255)));
        write_reg(REG_BASE_R, CFG_DATA_W'($urandom_range(255)));
        write_reg(REG_SEARCH, CFG_DATA_W'($urandom_range(255)));
        write_reg(REG_CONF, CFG_DATA_W'($urandom_range(3072)));
    endtask

    initial begin
        s_in.valid <= 0;
        s_in.sample_left <= 0;
        s_in.sample_centre <= 0;
        s_in.sample_right <= 0;
        steady_rx = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed with reset settings
        send_word(0, 0, 0, 0);
        send_word(10'h3ff, 10'h3ff, 10'h3ff, 0);
        send_word(10'h3ff, 0, 0, 0);
        send_word(10'h3ff, 10'h3ff, 0, 0);
        send_word(0, 0, 0, 0);
        send_word(0, 0, 10'h3ff, 1);
        send_word(0, 10'h3ff, 10'h3ff, 1);
        send_word(0, 0, 0, 1);
        send_word(10'h2aa, 10'h155, 10'h2aa, 0);
        drain();

        // narrow spans (equal, inverted), zero threshold, extreme gains and speeds
        write_reg(REG_WHITE, {10'd500, 10'd1023, 10'd300});
        write_reg(REG_BLACK, {10'd524, 10'd0, 10'd300});
        write_reg(REG_CONF, CFG_DATA_W'(0));
        write_reg(REG_KP, CFG_DATA_W'(4095));
        write_reg(REG_KD, CFG_DATA_W'(4095));
        write_reg(REG_BASE_L, CFG_DATA_W'(255));
        write_reg(REG_BASE_R, CFG_DATA_W'(0));
        write_reg(REG_SEARCH, CFG_DATA_W'(255));
        send_word(0, 0, 0, 0);
        send_word(188, 10'h3ff, 0, 0);
        send_word(10'h3ff, 0, 189, 0);
        send_word(0, 0, 10'h3ff, 0);
        send_word(10'h3ff, 10'h3ff, 0, 0);
        drain();
        write_reg(REG_CONF, CFG_DATA_W'(3072));
        write_reg(REG_KP, CFG_DATA_W'(0));
        write_reg(REG_KD, CFG_DATA_W'(0));
        write_reg(REG_BASE_L, CFG_DATA_W'(0));
        write_reg(REG_SEARCH, CFG_DATA_W'(0));
        send_word(10'h3ff, 10'h3ff, 10'h3ff, 0);
        send_word(0, 0, 0, 0);
        send_word(10'h3ff, 10'h3ff, 10'h3ff, 0);
        drain();

        // random phases over random settings
        for (int ph = 0; ph < 16; ph++) begin
            random_config();
            if (ph % 4 == 0) write_reg(REG_CONF, CFG_DATA_W'($urandom_range(1100, 300)));
            steady_rx = (ph % 5 == 2);
            track_burst(125, steady_rx);
            drain();
        end
        steady_rx = 0;
        drain();
        $display("run: %0d words sent, %0d tracking and %0d searching results checked",
                 words_sent, tracked, searched);
        $display("covered 16 random register settings plus extreme and narrow calibrations");
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
